// File: hw/rtl/mfmsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmsd_pkg
// shared types, codes and reset values of the mfm sync detector and decoder
// ----------------------------------------------------------------------------
package mfmsd_pkg;

    // defaults of the top level parameters
    localparam int SENTINEL_BYTES_DEF = 4;
    localparam int COUNT_WIDTH_DEF    = 18;

    // fixed field widths
    localparam int PAT_W       = 32;
    localparam int PLEN_W      = 6;
    localparam int BLANK_W     = 16;
    localparam int TBYTES_W    = 14;
    localparam int MINBITS_W   = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    // track bytes plus up to 16384 sentinels
    localparam int BYTE_CNT_W  = TBYTES_W + 1;

    // register reset values
    localparam logic [PAT_W-1:0]     SYNC_PATTERN_RST = 32'hAAAA_9125;
    localparam logic [PLEN_W-1:0]    PATTERN_LEN_RST  = 6'd32;
    localparam logic [BLANK_W-1:0]   BLANKING_RST     = 16'd500;
    localparam logic [TBYTES_W-1:0]  SIDE0_BYTES_RST  = 14'h2700;
    localparam logic [TBYTES_W-1:0]  SIDE1_BYTES_RST  = 14'h2400;
    localparam logic [MINBITS_W-1:0] MIN_BITS_RST     = 18'(9400 * 16);

    typedef enum logic [1:0] {
        OP_BIT   = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_SENTINEL = 2'd1,
        KIND_STATUS   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BLANK = 2'd1,
        ST_LATE  = 2'd2,
        ST_TRUNC = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_PATTERN = 3'd0,
        CFG_PATTERN_LEN  = 3'd1,
        CFG_BLANKING     = 3'd2,
        CFG_SIDE0_BYTES  = 3'd3,
        CFG_SIDE1_BYTES  = 3'd4,
        CFG_MIN_BITS     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [PAT_W-1:0]     sync_pattern;
        logic [PLEN_W-1:0]    pattern_length;
        logic [BLANK_W-1:0]   blanking_bits;
        logic [TBYTES_W-1:0]  side0_bytes;
        logic [TBYTES_W-1:0]  side1_bytes;
        logic [MINBITS_W-1:0] min_bits_after_sync;
    } t_cfg;

    typedef struct packed {
        t_op  operation;
        logic mfm_bit;
        logic side;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
        t_status    status;
        logic       last;
    } t_result;

endpackage

// File: hw/rtl/mfmsd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmsd channel interfaces
// item, result and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mfmsd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       mfm_bit;
    logic       side;

    modport source (output valid, output operation, output mfm_bit, output side,
                    input ready);
    modport sink   (input valid, input operation, input mfm_bit, input side,
                    output ready);
endinterface

interface mfmsd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output kind, output byte_value, output status,
                    output last, input ready);
    modport sink   (input valid, input kind, input byte_value, input status,
                    input last, output ready);
endinterface

interface mfmsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/mfmsd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmsd_cfg_regs
// configuration register file, written by index
// ----------------------------------------------------------------------------
module mfmsd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [mfmsd_pkg::CFG_IDX_W-1:0]     i_wr_index,
    input  logic [mfmsd_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output mfmsd_pkg::t_cfg                     o_cfg
);
    import mfmsd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_SYNC_PATTERN: n_cfg.sync_pattern        = i_wr_data[PAT_W-1:0];
                CFG_PATTERN_LEN:  n_cfg.pattern_length      = i_wr_data[PLEN_W-1:0];
                CFG_BLANKING:     n_cfg.blanking_bits       = i_wr_data[BLANK_W-1:0];
                CFG_SIDE0_BYTES:  n_cfg.side0_bytes         = i_wr_data[TBYTES_W-1:0];
                CFG_SIDE1_BYTES:  n_cfg.side1_bytes         = i_wr_data[TBYTES_W-1:0];
                CFG_MIN_BITS:     n_cfg.min_bits_after_sync = i_wr_data[MINBITS_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_pattern        <= SYNC_PATTERN_RST;
            r_cfg.pattern_length      <= PATTERN_LEN_RST;
            r_cfg.blanking_bits       <= BLANKING_RST;
            r_cfg.side0_bytes         <= SIDE0_BYTES_RST;
            r_cfg.side1_bytes         <= SIDE1_BYTES_RST;
            r_cfg.min_bits_after_sync <= MIN_BITS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/mfmsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmsd_core
// track state, sync hunt and data cell packing for one item per enabled cycle
// ----------------------------------------------------------------------------
module mfmsd_core #(
    parameter int SENTINEL_BYTES = mfmsd_pkg::SENTINEL_BYTES_DEF,
    parameter int COUNT_WIDTH    = mfmsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  mfmsd_pkg::t_item    i_item,
    input  mfmsd_pkg::t_cfg     i_cfg,
    output logic                o_res_valid,
    output mfmsd_pkg::t_result  o_res
);
    import mfmsd_pkg::*;

    localparam int IDX_W = COUNT_WIDTH + 2;
    localparam int CMP_W = (COUNT_WIDTH > MINBITS_W) ? COUNT_WIDTH : MINBITS_W;

    logic [PAT_W-1:0]       r_pattern_shift, n_pattern_shift;
    logic [COUNT_WIDTH-1:0] r_bit_count, n_bit_count;
    logic                   r_sync_found, n_sync_found;
    logic [COUNT_WIDTH-1:0] r_bits_since_sync, n_bits_since_sync;
    logic                   r_cell_phase, n_cell_phase;
    logic [7:0]             r_byte_shift, n_byte_shift;
    logic [2:0]             r_bits_in_byte, n_bits_in_byte;
    logic [BYTE_CNT_W-1:0]  r_byte_count, n_byte_count;
    logic                   r_latched_side, n_latched_side;

    logic [PLEN_W-1:0]      len;
    logic [PAT_W-1:0]       mask;
    logic [PAT_W-1:0]       shifted;
    logic                   pos_ok;
    logic [TBYTES_W-1:0]    track_bytes;
    logic [BYTE_CNT_W-1:0]  total;
    t_status                end_status;

    // effective pattern length, clamped to 1..32
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            len = PLEN_W'(1);
        end else if (i_cfg.pattern_length > PLEN_W'(PAT_W)) begin
            len = PLEN_W'(PAT_W);
        end else begin
            len = i_cfg.pattern_length;
        end
    end

    assign mask        = ~({PAT_W{1'b1}} << len);
    assign shifted     = {r_pattern_shift[PAT_W-2:0], i_item.mfm_bit};
    assign pos_ok      = (IDX_W'(r_bit_count) + IDX_W'(1))
                         >= (IDX_W'(i_cfg.blanking_bits) + IDX_W'(len));
    assign track_bytes = r_latched_side ? i_cfg.side1_bytes : i_cfg.side0_bytes;
    assign total       = BYTE_CNT_W'(track_bytes) + BYTE_CNT_W'(SENTINEL_BYTES);

    always_comb begin
        priority if (!r_sync_found) begin
            end_status = ST_BLANK;
        end else if (CMP_W'(r_bits_since_sync) < CMP_W'(i_cfg.min_bits_after_sync)) begin
            end_status = ST_LATE;
        end else if (r_byte_count < total) begin
            end_status = ST_TRUNC;
        end else begin
            end_status = ST_OK;
        end
    end

    always_comb begin
        n_pattern_shift   = r_pattern_shift;
        n_bit_count       = r_bit_count;
        n_sync_found      = r_sync_found;
        n_bits_since_sync = r_bits_since_sync;
        n_cell_phase      = r_cell_phase;
        n_byte_shift      = r_byte_shift;
        n_bits_in_byte    = r_bits_in_byte;
        n_byte_count      = r_byte_count;
        n_latched_side    = r_latched_side;
        o_res_valid       = 1'b0;
        o_res.kind        = KIND_DATA;
        o_res.byte_value  = '0;
        o_res.status      = ST_OK;
        o_res.last        = 1'b0;

        unique case (i_item.operation)
            OP_START, OP_END: begin
                if (i_item.operation == OP_START) begin
                    n_latched_side = i_item.side;
                end else begin
                    o_res_valid  = 1'b1;
                    o_res.kind   = KIND_STATUS;
                    o_res.status = end_status;
                    o_res.last   = 1'b1;
                end
                // clear all track state
                n_pattern_shift   = '0;
                n_bit_count       = '0;
                n_sync_found      = 1'b0;
                n_bits_since_sync = '0;
                n_cell_phase      = 1'b0;
                n_byte_shift      = '0;
                n_bits_in_byte    = '0;
                n_byte_count      = '0;
            end
            OP_BIT: begin
                n_pattern_shift = shifted;
                if (r_bit_count != {COUNT_WIDTH{1'b1}}) begin
                    n_bit_count = r_bit_count + COUNT_WIDTH'(1);
                end
                if (!r_sync_found) begin
                    if (pos_ok && (((shifted ^ i_cfg.sync_pattern) & mask) == '0)) begin
                        n_sync_found      = 1'b1;
                        n_bits_since_sync = COUNT_WIDTH'(len);
                        n_cell_phase      = 1'b0;
                        n_byte_shift      = '0;
                        n_bits_in_byte    = '0;
                        n_byte_count      = '0;
                    end
                end else begin
                    if (r_bits_since_sync != {COUNT_WIDTH{1'b1}}) begin
                        n_bits_since_sync = r_bits_since_sync + COUNT_WIDTH'(1);
                    end
                    n_cell_phase = ~r_cell_phase;
                    // data cell while bytes remain
                    if (r_cell_phase && (r_byte_count < total)) begin
                        if (r_bits_in_byte != 3'd7) begin
                            n_byte_shift   = {r_byte_shift[6:0], i_item.mfm_bit};
                            n_bits_in_byte = r_bits_in_byte + 3'd1;
                        end else begin
                            o_res_valid      = 1'b1;
                            o_res.kind       = (r_byte_count < BYTE_CNT_W'(track_bytes))
                                               ? KIND_DATA : KIND_SENTINEL;
                            o_res.byte_value = {r_byte_shift[6:0], i_item.mfm_bit};
                            o_res.last       = ((r_byte_count + BYTE_CNT_W'(1)) == total);
                            n_byte_shift     = '0;
                            n_bits_in_byte   = '0;
                            n_byte_count     = r_byte_count + BYTE_CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_shift   <= '0;
            r_bit_count       <= '0;
            r_sync_found      <= 1'b0;
            r_bits_since_sync <= '0;
            r_cell_phase      <= 1'b0;
            r_byte_shift      <= '0;
            r_bits_in_byte    <= '0;
            r_byte_count      <= '0;
            r_latched_side    <= 1'b0;
        end else if (i_en) begin
            r_pattern_shift   <= n_pattern_shift;
            r_bit_count       <= n_bit_count;
            r_sync_found      <= n_sync_found;
            r_bits_since_sync <= n_bits_since_sync;
            r_cell_phase      <= n_cell_phase;
            r_byte_shift      <= n_byte_shift;
            r_bits_in_byte    <= n_bits_in_byte;
            r_byte_count      <= n_byte_count;
            r_latched_side    <= n_latched_side;
        end
    end

    // bytes only come out of a track whose sync mark was seen
    a_byte_needs_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res_valid && (o_res.kind != KIND_STATUS)) |-> r_sync_found)
        else $error("byte result without sync");

    // no byte assembly before sync
    a_idle_before_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sync_found |-> ((r_byte_count == '0) && (r_bits_in_byte == '0)
                           && (r_byte_shift == '0)))
        else $error("byte state busy before sync");

    // end of track clears the track
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (i_item.operation == OP_END)) |=>
            (!r_sync_found && (r_bit_count == '0) && (r_byte_count == '0)))
        else $error("track state kept after end of track");

    // a byte result lands exactly when a data cell completes a byte
    a_byte_on_eighth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res_valid && (o_res.kind != KIND_STATUS)) |->
            (r_cell_phase && (r_bits_in_byte == 3'd7)))
        else $error("byte result off a byte boundary");

endmodule

// File: hw/rtl/mfm_sync_detect_and_data_extract_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfm_sync_detect_and_data_extract_top
// datapath: an accepted item waits in the input register, the core updates the
//   track state from it, and any result it gives is held in the output register
// throughput: one item per cycle while the result consumer keeps the output drained
// reset: synchronous active-low, restores registers to defaults, side 0
// ----------------------------------------------------------------------------
module mfm_sync_detect_and_data_extract_top #(
    parameter int SENTINEL_BYTES = mfmsd_pkg::SENTINEL_BYTES_DEF,
    parameter int COUNT_WIDTH    = mfmsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mfmsd_item_if.sink      i_item,
    mfmsd_result_if.source  o_result,
    mfmsd_cfg_if.sink       i_cfg
);
    import mfmsd_pkg::*;

    // input register: holds one request until the core can take it
    logic    r_in_valid;
    t_item   r_in;

    // output register: parts the core from the result consumer
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    proc_fire;
    logic    in_fire;
    logic    core_valid;
    t_result core_res;
    t_cfg    cfg;

    // the core may run when the output register is empty or being drained
    assign out_free  = !r_out_valid || o_result.ready;
    assign proc_fire = r_in_valid && out_free;
    // a new request enters whenever the input register frees up this cycle
    assign i_item.ready = !r_in_valid || proc_fire;
    assign in_fire      = i_item.valid && i_item.ready;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    mfmsd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    mfmsd_core #(
        .SENTINEL_BYTES (SENTINEL_BYTES),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (proc_fire),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.operation <= t_op'(i_item.operation);
            r_in.mfm_bit   <= i_item.mfm_bit;
            r_in.side      <= i_item.side;
        end
    end

    // output stage control: load on a produced result, else drain on ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && core_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && core_valid) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.kind       = r_out.kind;
    assign o_result.byte_value = r_out.byte_value;
    assign o_result.status     = r_out.status;
    assign o_result.last       = r_out.last;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for mfm_sync_detect_and_data_extract_top
// feeds tracks of raw mfm cells with random content under random valid/ready
// gaps, predicts every decoded byte and track status with its own decoder
// model and compares each result with the oldest prediction
// ----------------------------------------------------------------------------
import mfmsd_pkg::*;

localparam int SENTINELS = SENTINEL_BYTES_DEF;
localparam int CNT_W     = COUNT_WIDTH_DEF;

class mfm_track_scoreboard;
    t_cfg              regs;
    logic [31:0]       cell_hist;
    logic [CNT_W-1:0]  cells_seen;
    bit                locked;
    logic [CNT_W-1:0]  cells_locked;
    bit                data_next;
    logic [7:0]        acc;
    logic [2:0]        acc_n;
    logic [BYTE_CNT_W-1:0] bytes_done;
    bit                head;
    t_result           track_output_q[$];

    function new();
        regs.sync_pattern        = SYNC_PATTERN_RST;
        regs.pattern_length      = PATTERN_LEN_RST;
        regs.blanking_bits       = BLANKING_RST;
        regs.side0_bytes         = SIDE0_BYTES_RST;
        regs.side1_bytes         = SIDE1_BYTES_RST;
        regs.min_bits_after_sync = MIN_BITS_RST;
        head = 1'b0;
        clear_track();
    endfunction

    function void clear_track();
        cell_hist    = '0;
        cells_seen   = '0;
        locked       = 1'b0;
        cells_locked = '0;
        data_next    = 1'b0;
        acc          = '0;
        acc_n        = '0;
        bytes_done   = '0;
    endfunction

    // zero compares one bit, anything above 32 compares 32
    static function int sync_len_of(logic [PLEN_W-1:0] n);
        if (n == 0) return 1;
        if (n > 32) return 32;
        return int'(n);
    endfunction

    function int track_bytes();
        return head ? int'(regs.side1_bytes) : int'(regs.side0_bytes);
    endfunction

    function void write_reg(t_cfg_idx idx, logic [31:0] d);
        case (idx)
            CFG_SYNC_PATTERN: regs.sync_pattern        = d;
            CFG_PATTERN_LEN:  regs.pattern_length      = d[PLEN_W-1:0];
            CFG_BLANKING:     regs.blanking_bits       = d[BLANK_W-1:0];
            CFG_SIDE0_BYTES:  regs.side0_bytes         = d[TBYTES_W-1:0];
            CFG_SIDE1_BYTES:  regs.side1_bytes         = d[TBYTES_W-1:0];
            CFG_MIN_BITS:     regs.min_bits_after_sync = d[MINBITS_W-1:0];
            default: ;
        endcase
    endfunction

    function void push(t_kind k, logic [7:0] v, t_status s, bit l);
        t_result r;
        r.kind       = k;
        r.byte_value = v;
        r.status     = s;
        r.last       = l;
        track_output_q = {track_output_q, r};
    endfunction

    function void note_request(t_item req);
        int idx;
        int len;
        int tb;
        int total;
        logic [31:0] mask;
        bit was_data;
        case (req.operation)
            OP_START: begin
                clear_track();
                head = req.side;
            end
            OP_END: begin
                total = track_bytes() + SENTINELS;
                if (!locked)
                    push(KIND_STATUS, 8'h00, ST_BLANK, 1'b1);
                else if (int'(cells_locked) < int'(regs.min_bits_after_sync))
                    push(KIND_STATUS, 8'h00, ST_LATE, 1'b1);
                else if (int'(bytes_done) < total)
                    push(KIND_STATUS, 8'h00, ST_TRUNC, 1'b1);
                else
                    push(KIND_STATUS, 8'h00, ST_OK, 1'b1);
                clear_track();
            end
            OP_BIT: begin
                idx = int'(cells_seen);
                len = sync_len_of(regs.pattern_length);
                cell_hist = {cell_hist[30:0], req.mfm_bit};
                if (~&cells_seen) cells_seen++;
                if (!locked) begin
                    mask = (len >= 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 32'd1);
                    if (idx + 1 >= int'(regs.blanking_bits) + len &&
                        ((cell_hist ^ regs.sync_pattern) & mask) == 32'd0) begin
                        locked       = 1'b1;
                        cells_locked = len[CNT_W-1:0];
                        data_next    = 1'b0;
                        acc          = '0;
                        acc_n        = '0;
                        bytes_done   = '0;
                    end
                end else begin
                    if (~&cells_locked) cells_locked++;
                    tb = track_bytes();
                    total = tb + SENTINELS;
                    was_data = data_next;
                    data_next = ~data_next;
                    if (was_data && int'(bytes_done) < total) begin
                        acc = {acc[6:0], req.mfm_bit};
                        if (acc_n != 3'd7) begin
                            acc_n++;
                        end else begin
                            acc_n = '0;
                            push((int'(bytes_done) < tb) ? KIND_DATA : KIND_SENTINEL, acc,
                                 ST_OK, int'(bytes_done) + 1 == total);
                            bytes_done++;
                            acc = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function string check_output(t_result got);
        t_result want;
        string diffs;
        if (track_output_q.size() == 0)
            return $sformatf("result kind %0d value %02h status %0d last %0b, no request pending",
                             got.kind, got.byte_value, got.status, got.last);
        want = track_output_q.pop_front();
        diffs = "";
        if (got.kind !== want.kind)
            diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
        if (got.byte_value !== want.byte_value)
            diffs = {diffs, $sformatf(" value %02h/%02h", got.byte_value, want.byte_value)};
        if (got.status !== want.status)
            diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
        if (got.last !== want.last)
            diffs = {diffs, $sformatf(" last %0b/%0b", got.last, want.last)};
        if (diffs != "") return {"result differs (got/wanted):", diffs};
        return "";
    endfunction

    function int outstanding();
        return track_output_q.size();
    endfunction
endclass

module testbench;

    // watchdog: cycles in a row with no accepted request, result or write
    localparam int STALL_LIMIT     = 2000;
    // idle cycles after the last predicted result, to let the block go quiet
    localparam int DRAIN_CYCLES    = 4;
    localparam int RANDOM_REQUESTS = 1200;
    localparam int MAX_PRINTED     = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mfmsd_item_if   item_ch ();
    mfmsd_result_if res_ch ();
    mfmsd_cfg_if    cfg_ch ();

    mfm_sync_detect_and_data_extract_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    mfm_track_scoreboard sb;
    t_cfg cur_cfg;           // settings last written, used to shape tracks
    int   error_count  = 0;
    int   stall_cycles = 0;
    int   requests_sent = 0; // ignored requests are left out
    bit   send_gaps = 1'b1;
    bit   recv_gaps = 1'b1;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        if (error_count < MAX_PRINTED) $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    // monitor: all handshakes are sampled at the edge that completes them;
    // results are checked before the request of the same edge is noted, the
    // order of the queue keeps either ordering correct
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_item   req;
        string   msg;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.kind       = t_kind'(res_ch.kind);
                got.byte_value = res_ch.byte_value;
                got.status     = t_status'(res_ch.status);
                got.last       = res_ch.last;
                msg = sb.check_output(got);
                if (msg != "") report(msg);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_reg(t_cfg_idx'(cfg_ch.index), cfg_ch.data);
                moved = 1'b1;
            end
            if (item_ch.valid && item_ch.ready) begin
                req.operation = t_op'(item_ch.operation);
                req.mfm_bit   = item_ch.mfm_bit;
                req.side      = item_ch.side;
                sb.note_request(req);
                moved = 1'b1;
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    // watchdog
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // result sink: random hold-off before each result, ready stays high
    // while waiting so a result is taken at the first edge it shows
    initial begin : result_sink
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = recv_gaps ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // one request; valid stays high into the next request when no gap is drawn
    task automatic send_item(input t_op op, input logic b, input logic s);
        int gap;
        gap = send_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.mfm_bit   <= b;
        item_ch.side      <= s;
        do @(posedge i_clk); while (!item_ch.ready);
        if (op != OP_RSVD) requests_sent++;
    endtask

    // raw cell with a random side field
    task automatic send_cell(input logic b);
        send_item(OP_BIT, b, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise();
        send_item(OP_RSVD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // hold the sender until every predicted result is out, then let the
    // block go quiet; the first edge makes sure the last request is noted
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write, unused upper data bits carry random junk
    task automatic cfg_request(input t_cfg_idx idx, input logic [31:0] val, input int width);
        logic [31:0] junk;
        junk = (width >= 32) ? 32'd0 : ($urandom << width);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val | junk;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic write_cfg(input t_cfg c);
        cur_cfg = c;
        cfg_request(CFG_SYNC_PATTERN, 32'(c.sync_pattern), PAT_W);
        cfg_request(CFG_PATTERN_LEN, 32'(c.pattern_length), PLEN_W);
        cfg_request(CFG_BLANKING, 32'(c.blanking_bits), BLANK_W);
        cfg_request(CFG_SIDE0_BYTES, 32'(c.side0_bytes), TBYTES_W);
        cfg_request(CFG_SIDE1_BYTES, 32'(c.side1_bytes), TBYTES_W);
        cfg_request(CFG_MIN_BITS, 32'(c.min_bits_after_sync), MINBITS_W);
        cfg_ch.valid <= 1'b0;
    endtask

    // small settings keep tracks short; the first few hit the corners
    function automatic t_cfg random_cfg(input int step);
        t_cfg c;
        int room;
        c.sync_pattern   = $urandom;
        c.pattern_length = PLEN_W'($urandom_range(1, 32));
        c.blanking_bits  = BLANK_W'($urandom_range(0, 24));
        c.side0_bytes    = TBYTES_W'($urandom_range(0, 4));
        c.side1_bytes    = TBYTES_W'($urandom_range(0, 4));
        case (step)
            0: begin
                // one-bit pattern, no blanking, sentinel bytes only
                c.pattern_length = PLEN_W'(1);
                c.blanking_bits  = '0;
                c.side0_bytes    = '0;
                c.side1_bytes    = '0;
            end
            1: begin
                c.sync_pattern   = '1;
                c.pattern_length = PLEN_W'(32);
                c.blanking_bits  = '0;
            end
            2: begin
                // zero length acts as one bit
                c.sync_pattern   = '0;
                c.pattern_length = '0;
            end
            3: c.pattern_length = '1;  // over 32 acts as 32
            default: begin
                if ($urandom_range(0, 7) == 0)
                    c.pattern_length = PLEN_W'($urandom_range(33, 63));
                if ($urandom_range(0, 15) == 0) c.pattern_length = '0;
            end
        endcase
        room = 16 * (((c.side0_bytes > c.side1_bytes) ? c.side0_bytes : c.side1_bytes)
                     + SENTINELS) + 40;
        c.min_bits_after_sync = (step == 0) ? 18'd0 : 18'($urandom_range(0, room));
        return c;
    endfunction

    // one track: start, lead-in noise, sync pattern, clock/data cells, end;
    // an untidy track may skip start or end, sync early, corrupt the pattern
    // or stop short
    task automatic run_track(input bit tidy, input bit allow_gaps);
        int lead;
        int len;
        int body;
        int need;
        int pos;
        int most;
        logic s;
        logic [31:0] pat;
        s = 1'($urandom_range(0, 1));
        send_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
        recv_gaps = ($urandom_range(0, 3) != 0);
        if (tidy || $urandom_range(0, 2) != 0)
            send_item(OP_START, 1'($urandom_range(0, 1)), s);
        len = sb.sync_len_of(cur_cfg.pattern_length);
        lead = int'(cur_cfg.blanking_bits) + $urandom_range(0, 6);
        if (!tidy && $urandom_range(0, 1) == 0) lead = $urandom_range(0, lead);
        repeat (lead) send_cell(1'($urandom_range(0, 1)));
        pat = cur_cfg.sync_pattern;
        if (!tidy && $urandom_range(0, 2) == 0) begin
            pos = $urandom_range(0, len - 1);
            pat[pos] = ~pat[pos];
        end
        for (int i = len - 1; i >= 0; i--) send_cell(pat[i]);
        most = (cur_cfg.side0_bytes > cur_cfg.side1_bytes) ? int'(cur_cfg.side0_bytes)
                                                           : int'(cur_cfg.side1_bytes);
        need = 16 * (most + SENTINELS) + 8;
        if (tidy) begin
            body = (need > int'(cur_cfg.min_bits_after_sync)) ? need
                                                             : int'(cur_cfg.min_bits_after_sync);
            body += $urandom_range(0, 24);
        end else begin
            body = $urandom_range(0, need + 16);
        end
        for (int n = 0; n < body; n++) begin
            if ($urandom_range(0, 39) == 0) send_noise();
            // now and then the sender waits for the block to empty
            if ($urandom_range(0, 299) == 0) settle();
            send_cell(1'($urandom_range(0, 1)));
        end
        if (tidy || $urandom_range(0, 3) != 0)
            send_item(OP_END, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin : stimulus
        int step;
        sb = new();
        cur_cfg = sb.regs;
        i_rst_n           <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.operation <= OP_BIT;
        item_ch.mfm_bit   <= 1'b0;
        item_ch.side      <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_SYNC_PATTERN;
        cfg_ch.data       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: cells with no start of track decode as
        // side 0, ignored operation, end with no sync is blank
        send_item(OP_BIT, 1'b0, 1'b0);
        send_item(OP_BIT, 1'b1, 1'b1);
        send_item(OP_RSVD, 1'b0, 1'b0);
        send_item(OP_RSVD, 1'b1, 1'b1);
        send_item(OP_END, 1'b1, 1'b1);
        // back-to-back end, then short tracks on both heads
        send_item(OP_END, 1'b0, 1'b1);
        send_item(OP_START, 1'b1, 1'b1);
        send_item(OP_BIT, 1'b1, 1'b0);
        send_item(OP_END, 1'b0, 1'b0);
        send_item(OP_START, 1'b0, 1'b0);
        send_item(OP_END, 1'b1, 1'b0);

        // random tracks, a fresh setting every one to three tracks
        step = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            settle();
            write_cfg(random_cfg(step));
            repeat ($urandom_range(1, 3)) run_track($urandom_range(0, 4) != 0, 1'b1);
            step++;
        end

        settle();
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mfmsd_pkg.sv
hw/rtl/mfmsd_if.sv
hw/rtl/mfmsd_cfg_regs.sv
hw/rtl/mfmsd_core.sv
hw/rtl/mfm_sync_detect_and_data_extract_top.sv
tb/testbench.sv
